FILE: src/mdws_pkg.sv
// Package for the max distinct window sum block: sizes, widths and the
// control bundle that the controller sends along the cell chain.
// No dependencies.
package mdws_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int CELL_IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int VALUE_W    = 32;
   localparam int SUM_W      = 38;
   localparam int BEST_W     = 37;
   localparam int LEN_W      = 7;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic             shift;      // a new value enters the chain
      logic             step;       // one scan step of the duplicate search
      logic [CNT_W-1:0] probe_age;  // age of the value now on the probe line
      logic [CNT_W-1:0] held;       // number of values in the current window
   } chain_ctrl_type;

endpackage

FILE: src/mdws_req_if.sv
// Input channel of the max distinct window sum block: valid/ready
// handshake with one value and its start mark. Depends on mdws_pkg.
interface mdws_req_if;
   import mdws_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      start_req;

   modport source (output valid, output value, output start_req, input ready);
   modport sink   (input valid, input value, input start_req, output ready);
endinterface

FILE: src/mdws_rsp_if.sv
// Result channel of the max distinct window sum block: valid/ready
// handshake with the best sum and the window flag. Depends on mdws_pkg.
interface mdws_rsp_if;
   import mdws_pkg::*;

   logic              valid;
   logic              ready;
   logic [BEST_W-1:0] best_sum;
   logic              window_valid;

   modport source (output valid, output best_sum, output window_valid, input ready);
   modport sink   (input valid, input best_sum, input window_valid, output ready);
endinterface

FILE: src/mdws_cell.sv
// One cell of the window chain: holds one stored value and one scan copy,
// and compares its stored value against the broadcast probe.
// Depends on mdws_pkg.
module mdws_cell (
   input  logic                         clock,
   input  logic [mdws_pkg::CELL_IDX_W-1:0] cell_idx,
   input  mdws_pkg::chain_ctrl_type     ctrl,
   input  mdws_pkg::value_type          left_value,
   input  mdws_pkg::value_type          right_scan,
   input  mdws_pkg::value_type          probe,
   output mdws_pkg::value_type          value_out,
   output mdws_pkg::value_type          scan_out,
   output logic                         hit
);
   import mdws_pkg::*;

   value_type        stored_ff, stored_in;
   value_type        scan_ff, scan_in;
   logic [CNT_W-1:0] idx_ext;

   assign idx_ext = CNT_W'(cell_idx);

   always_comb begin
      stored_in = stored_ff;
      scan_in   = scan_ff;
      if (ctrl.shift) begin
         stored_in = left_value;
         // The scan copy loads what the stored value becomes on this edge.
         scan_in   = left_value;
      end else if (ctrl.step) begin
         scan_in = right_scan;
      end
   end

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
      scan_ff   <= scan_in;
   end

   // Only cells older than the probe and inside the window take part, so
   // every equal pair is seen once, from its younger member.
   assign hit = ctrl.step && (idx_ext > ctrl.probe_age) && (idx_ext < ctrl.held)
                && (stored_ff == probe);

   assign value_out = stored_ff;
   assign scan_out  = scan_ff;

endmodule

FILE: src/mdws_chain.sv
// Row of window cells: values shift in at cell 0 on each transfer, and the
// scan copies shift toward cell 0 to put each window value on the probe
// line in turn. Depends on mdws_pkg and mdws_cell.
module mdws_chain (
   input  logic                     clock,
   input  mdws_pkg::chain_ctrl_type ctrl,
   input  mdws_pkg::value_type      new_value,
   output mdws_pkg::value_type      probe,
   output logic                     hit_any
);
   import mdws_pkg::*;

   value_type             values [MAX_WINDOW];
   value_type             scans  [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] hits;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      value_type left_v;
      value_type right_s;

      if (i == 0) begin : g_first
         assign left_v = new_value;
      end else begin : g_inner
         assign left_v = values[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_s = '0;
      end else begin : g_mid
         assign right_s = scans[i+1];
      end

      mdws_cell u_cell (
         .clock      (clock),
         .cell_idx   (CELL_IDX_W'(i)),
         .ctrl       (ctrl),
         .left_value (left_v),
         .right_scan (right_s),
         .probe      (probe),
         .value_out  (values[i]),
         .scan_out   (scans[i]),
         .hit        (hits[i])
      );
   end

   assign probe   = scans[0];
   assign hit_any = |hits;

endmodule

FILE: src/max_distinct_window_sum.sv
// Max distinct window sum: each input transfer starts a scan of the cell
// chain, one window value per cycle, over the held values, where held is
// the number of values in the window (1 to 64); the result is registered
// after the scan, and no new value is taken until it has been registered.
// Synchronous active-high reset clears the controller, window length (3),
// fill count and best sum; stored window values are not cleared.
module max_distinct_window_sum (
   input  logic                            clock,
   input  logic                            reset,
   mdws_req_if.sink                        req_chan,
   mdws_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [mdws_pkg::LEN_W-1:0]      csr_wr_data
);
   import mdws_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  age_ff, age_in;
   logic              full_ff, full_in;
   logic              dup_ff, dup_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BEST_W-1:0] best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0] rsp_best_ff, rsp_best_in;
   logic              rsp_win_ff, rsp_win_in;

   logic              accept;
   logic [CNT_W-1:0]  k_eff;
   logic [CNT_W-1:0]  fill_next;
   logic              win_ok;
   logic              better;
   logic              out_free;
   chain_ctrl_type    ctrl;
   value_type         probe;
   logic              hit_any;

   assign accept   = (state_ff == S_IDLE) && req_chan.valid;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // A length of zero acts as one; anything past the chain acts as the chain.
   always_comb begin
      if (len_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (CNT_W'(len_ff) > CNT_W'(MAX_WINDOW)) begin
         k_eff = CNT_W'(MAX_WINDOW);
      end else begin
         k_eff = CNT_W'(len_ff);
      end
   end

   always_comb begin
      if (req_chan.start_req) begin
         fill_next = CNT_W'(1);
      end else if (fill_ff < CNT_W'(MAX_WINDOW)) begin
         fill_next = fill_ff + CNT_W'(1);
      end else begin
         fill_next = fill_ff;
      end
   end

   assign win_ok = full_ff && !dup_ff;
   assign better = win_ok && !sum_ff[SUM_W-1] && (sum_ff[BEST_W-1:0] > best_ff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      held_in      = held_ff;
      age_in       = age_ff;
      full_in      = full_ff;
      dup_in       = dup_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_win_in   = rsp_win_ff;

      if (csr_wr_en) begin
         len_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fill_in  = fill_next;
               held_in  = (fill_next < k_eff) ? fill_next : k_eff;
               full_in  = (fill_next >= k_eff);
               age_in   = '0;
               dup_in   = 1'b0;
               sum_in   = '0;
               if (req_chan.start_req) begin
                  best_in = '0;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            sum_in = sum_ff + SUM_W'(probe);
            dup_in = dup_ff | hit_any;
            age_in = age_ff + CNT_W'(1);
            if (age_ff == held_ff - CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               if (better) begin
                  best_in     = sum_ff[BEST_W-1:0];
                  rsp_best_in = sum_ff[BEST_W-1:0];
               end else begin
                  rsp_best_in = best_ff;
               end
               rsp_win_in   = win_ok;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LEN_RESET;
         fill_ff      <= '0;
         held_ff      <= '0;
         age_ff       <= '0;
         full_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         sum_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         held_ff      <= held_in;
         age_ff       <= age_in;
         full_ff      <= full_in;
         dup_ff       <= dup_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_best_ff <= rsp_best_in;
      rsp_win_ff  <= rsp_win_in;
   end

   assign ctrl.shift     = accept;
   assign ctrl.step      = (state_ff == S_SCAN);
   assign ctrl.probe_age = age_ff;
   assign ctrl.held      = held_ff;

   mdws_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .new_value (req_chan.value),
      .probe     (probe),
      .hit_any   (hit_any)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.best_sum     = rsp_best_ff;
   assign rsp_chan.window_valid = rsp_win_ff;

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (age_ff < held_ff))
      else $error("scan age ran past the window");

   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (held_ff != '0) && (held_ff <= fill_ff))
      else $error("window size exceeds the values held");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN))
      else $error("transfer did not start a scan");

   a_best_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.start_req) |=> (best_ff == $past(best_ff)))
      else $error("best sum changed on a transfer without start");

   a_result_best: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && out_free) |=> (rsp_best_ff == best_ff))
      else $error("reported best sum differs from the kept best sum");

endmodule
